[hw/rtl/kts_pkg.sv]
// Package for the keyed record table: opcodes, status codes, payload structs.
// No dependencies; used by the top level keyed_table_with_extreme_select.
package kts_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpUpdate = 3'd1;
  localparam logic [2:0] OpDelete = 3'd2;
  localparam logic [2:0] OpMin    = 3'd3;
  localparam logic [2:0] OpMax    = 3'd4;
  localparam logic [2:0] OpMin2   = 3'd5;
  localparam logic [2:0] OpMax2   = 3'd6;
  localparam logic [2:0] OpIgnore = 3'd7;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StFull    = 3'd1;
  localparam logic [2:0] StDup     = 3'd2;
  localparam logic [2:0] StMissing = 3'd3;
  localparam logic [2:0] StFew     = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [63:0]        key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        found_key;
    logic signed [31:0] found_value;
    logic [6:0]         found_index;
    logic [7:0]         record_count;
  } rsp_t;

endpackage

[hw/rtl/kts_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module kts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read on one port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hw/rtl/keyed_table_with_extreme_select.sv]
// Top level of the keyed record table: sequencer, shared compare unit, two RAMs.
// Depends on kts_pkg and kts_ram.
//
// The block holds up to 128 records (64-bit key, signed Q16.16 value) in two
// single-port RAMs and walks them one entry per cycle with one address
// sequencer and one comparator. A transaction is taken when start_i is high
// and busy_o is low; busy_o stays high until the result is shown for one
// cycle with done_o, which the receiver cannot stall. Insert and update run a
// key search, then a write; delete runs a key search, then moves each later
// record down with a read and a write; min/max run a scan, then read back the
// chosen entry; second min/max run two full scans, then the read-back. An
// insert into a full table, a query on too few records, update or delete on
// an empty table and opcode 7 answer without a scan; an insert into an empty
// table does just the write. The block returns to idle after each result before
// the next transaction is taken. The RAM port allows one access per cycle.
module keyed_table_with_extreme_select (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  kts_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output kts_pkg::rsp_t rsp_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;  // issue reads, compare trailing data
  localparam logic [2:0] SDrain = 3'd2;  // last read data arrives
  localparam logic [2:0] SWrite = 3'd3;  // write insert/update
  localparam logic [2:0] SMvRd  = 3'd4;  // delete: read entry i+1
  localparam logic [2:0] SMvWr  = 3'd5;  // delete: write entry i
  localparam logic [2:0] SFetch = 3'd6;  // read back chosen entry
  localparam logic [2:0] SDone  = 3'd7;

  logic [2:0]  state_q, state_d;
  kts_pkg::req_t req_q;
  logic [kts_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [kts_pkg::CntW-1:0] ptr_q, ptr_d;    // address issued
  logic [kts_pkg::CntW-1:0] cmp_q, cmp_d;    // index of data at RAM output
  logic [kts_pkg::CntW-1:0] best_q, best_d;  // count means none
  logic [kts_pkg::CntW-1:0] skip_q, skip_d;
  logic        pass2_q, pass2_d;
  logic [31:0] bestv_q, bestv_d;
  logic [31:0] dval_q, dval_d;
  kts_pkg::rsp_t rsp_q, rsp_d;

  logic                     we;
  logic [kts_pkg::IdxW-1:0] addr;
  logic [63:0]              wkey, rkey;
  logic [31:0]              wval, rval;
  logic                     is_max, better, rd_valid;

  kts_ram #(.Width(64), .Depth(kts_pkg::TableDepth)) u_key_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wkey), .rdata_o(rkey)
  );
  kts_ram #(.Width(32), .Depth(kts_pkg::TableDepth)) u_val_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wval), .rdata_o(rval)
  );

  assign is_max = (req_q.opcode == kts_pkg::OpMax) || (req_q.opcode == kts_pkg::OpMax2);
  // Shared signed comparator
  assign better = is_max ? ($signed(bestv_q) < $signed(rval))
                         : ($signed(rval) < $signed(bestv_q));

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    cmp_d   = cmp_q;
    best_d  = best_q;
    skip_d  = skip_q;
    pass2_d = pass2_q;
    bestv_d = bestv_q;
    dval_d  = dval_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    addr    = ptr_q[kts_pkg::IdxW-1:0];
    wkey    = req_q.key;
    wval    = req_q.value;
    rd_valid = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          ptr_d   = '0;
          cmp_d   = '0;
          best_d  = cnt_q;
          skip_d  = cnt_q;
          pass2_d = 1'b0;
          rsp_d   = '0;
          rsp_d.record_count = 8'(cnt_q);
          priority if (req_i.opcode == kts_pkg::OpInsert &&
                       cnt_q >= kts_pkg::CntW'(kts_pkg::TableDepth)) begin
            rsp_d.status = kts_pkg::StFull;
            state_d = SDone;
          end else if ((req_i.opcode == kts_pkg::OpMin || req_i.opcode == kts_pkg::OpMax)
                       && cnt_q == '0) begin
            rsp_d.status = kts_pkg::StFew;
            state_d = SDone;
          end else if ((req_i.opcode == kts_pkg::OpMin2 || req_i.opcode == kts_pkg::OpMax2)
                       && cnt_q < kts_pkg::CntW'(2)) begin
            rsp_d.status = kts_pkg::StFew;
            state_d = SDone;
          end else if (req_i.opcode == kts_pkg::OpIgnore) begin
            state_d = SDone;
          end else if (cnt_q == '0) begin
            // empty table: insert writes at once, update/delete miss
            if (req_i.opcode == kts_pkg::OpInsert) state_d = SWrite;
            else begin
              rsp_d.status = kts_pkg::StMissing;
              state_d = SDone;
            end
          end else begin
            state_d = SScan;
          end
        end
      end

      SScan, SDrain: begin
        if (state_q == SScan) begin
          ptr_d = ptr_q + 1'b1;
          if (ptr_q + 1'b1 == cnt_q) state_d = SDrain;
        end
        rd_valid = (state_q == SDrain) || (ptr_q != cmp_q);
        if (rd_valid) begin
          cmp_d = cmp_q + 1'b1;
          if (req_q.opcode == kts_pkg::OpInsert || req_q.opcode == kts_pkg::OpUpdate ||
              req_q.opcode == kts_pkg::OpDelete) begin
            if (best_q == cnt_q && rkey == req_q.key) begin
              best_d = cmp_q;
              dval_d = rval;
            end
          end else if (cmp_q != skip_q && (best_q == cnt_q || better)) begin
            best_d  = cmp_q;
            bestv_d = rval;
          end
        end
        if (state_q == SDrain) begin
          // scan finished
          unique case (req_q.opcode)
            kts_pkg::OpInsert: begin
              if (best_d != cnt_q) begin
                rsp_d.status = kts_pkg::StDup;
                state_d = SDone;
              end else state_d = SWrite;
            end
            kts_pkg::OpUpdate: begin
              if (best_d == cnt_q) begin
                rsp_d.status = kts_pkg::StMissing;
                state_d = SDone;
              end else state_d = SWrite;
            end
            kts_pkg::OpDelete: begin
              if (best_d == cnt_q) begin
                rsp_d.status = kts_pkg::StMissing;
                state_d = SDone;
              end else begin
                rsp_d.found_key   = req_q.key;
                rsp_d.found_value = dval_d;
                rsp_d.found_index = 7'(best_d);
                cnt_d = cnt_q - 1'b1;
                rsp_d.record_count = 8'(cnt_d);
                ptr_d = best_d;
                state_d = (best_d + 1'b1 == cnt_q) ? SDone : SMvRd;
              end
            end
            default: begin
              if ((req_q.opcode == kts_pkg::OpMin2 || req_q.opcode == kts_pkg::OpMax2)
                  && !pass2_q) begin
                // second pass excludes the primary extreme
                pass2_d = 1'b1;
                skip_d  = best_d;
                best_d  = cnt_q;
                ptr_d   = '0;
                cmp_d   = '0;
                state_d = SScan;
              end else begin
                ptr_d = best_d;
                state_d = SFetch;
              end
            end
          endcase
        end
      end

      SWrite: begin
        we = 1'b1;
        if (req_q.opcode == kts_pkg::OpInsert) begin
          addr = cnt_q[kts_pkg::IdxW-1:0];
          rsp_d.found_index = 7'(cnt_q);
          cnt_d = cnt_q + 1'b1;
        end else begin
          addr = best_q[kts_pkg::IdxW-1:0];
          rsp_d.found_index = 7'(best_q);
        end
        rsp_d.found_key    = req_q.key;
        rsp_d.found_value  = req_q.value;
        rsp_d.record_count = 8'(cnt_d);
        state_d = SDone;
      end

      SMvRd: begin
        addr = kts_pkg::IdxW'(ptr_q + 1'b1);
        state_d = SMvWr;
      end

      SMvWr: begin
        we   = 1'b1;
        wkey = rkey;
        wval = rval;
        ptr_d = ptr_q + 1'b1;
        state_d = (ptr_q + 1'b1 == cnt_q) ? SDone : SMvRd;
      end

      SFetch: begin
        state_d = SFetch;
        if (cmp_q == '1) begin
          rsp_d.found_key   = rkey;
          rsp_d.found_value = rval;
          rsp_d.found_index = 7'(best_q);
          state_d = SDone;
        end
        cmp_d = '1;
      end

      SDone: state_d = SIdle;

      default: state_d = SIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) req_q <= req_i;
    ptr_q   <= ptr_d;
    cmp_q   <= cmp_d;
    best_q  <= best_d;
    skip_q  <= skip_d;
    pass2_q <= pass2_d;
    bestv_q <= bestv_d;
    dval_q  <= dval_d;
    rsp_q   <= rsp_d;
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = (state_q == SDone);
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= kts_pkg::CntW'(kts_pkg::TableDepth))
    else $error("record count beyond table depth");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result shown twice");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |=> $stable(cnt_q))
    else $error("count moved while idle");
`endif

endmodule
